FILE: design/rpaa_pkg.sv
`default_nettype none
package rpaa_pkg;

  // width of the total registers and of the configuration data
  localparam int REG_BITS  = 20;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_POS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_NEG = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TPR,
    ST_DIV_FPR,
    ST_DIV_PREC,
    ST_MUL_ROC,
    ST_MUL_PR,
    ST_ACC_PR,
    ST_DONE
  } rpaa_state_t;

endpackage
`default_nettype wire

FILE: design/roc_pr_area_accumulator_unit.sv
`default_nettype none
// ROC / precision-recall accumulator over a ranked list.
// Input stream: in_tdata[0] is the label (1 = positive), in_tlast marks the
// final item of the list. Items arrive in descending score order.
// Output stream: one result per input. out_tdata carries the false positive
// rate, true positive rate (recall) and precision in Q1.FRAC_BITS, then the
// running ROC and PR trapezoid areas in Q1.(2*FRAC_BITS); out_tlast copies
// the input's last flag. The total registers are to be written through the
// cfg_ port only while the block is idle; the block does not enforce this.
// Each item runs three divisions on one shared restoring divider (a saturating
// one ends at once), then two multiply-accumulate steps on one multiplier;
// the sequencer takes a new item only once it is through with the last.
// in_tready is high only while the sequencer is idle.
// The result waits in an output register; the next item is taken while it
// waits, and its result is held back until the receiver takes the first.
// Reset (rst_n low, synchronous) clears the counts and areas, sets both total
// registers to 1 and empties the output register. After a result for an item
// marked last, the list state returns to its reset value.
module roc_pr_area_accumulator_unit
  import rpaa_pkg::*;
#(
  parameter int COUNT_BITS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [0] is_positive, zero padded
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // from bit 0: false_pos_rate, true_pos_rate, precision, roc_auc, pr_area, zero padded
  output logic [((3*(FRAC_BITS+1) + 2*(2*FRAC_BITS+1) + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                      out_tlast,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]  cfg_wdata
);

  localparam int RW    = FRAC_BITS + 1;
  localparam int AW    = 2 * FRAC_BITS + 1;
  localparam int DW    = (COUNT_BITS + 1 > REG_BITS) ? COUNT_BITS + 1 : REG_BITS;
  localparam int PW    = 2 * FRAC_BITS + 3;
  localparam int PAY_W = 3 * RW + 2 * AW;
  localparam int OUT_W = ((PAY_W + 7) / 8) * 8;

  localparam logic [RW-1:0] ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] ONE_AREA = {1'b1, {(2*FRAC_BITS){1'b0}}};

  rpaa_state_t state_r, state_nxt;

  logic [REG_BITS-1:0]   tot_pos_r, tot_neg_r;
  logic [COUNT_BITS-1:0] pos_r, neg_r;
  logic                  last_r;
  logic [RW-1:0]         tpr_r, fpr_r, prec_r;
  logic [RW-1:0]         prev_tpr_r, prev_fpr_r, prev_prec_r;
  logic [AW-1:0]         roc_sum_r, pr_sum_r;
  logic [PW-1:0]         prod_r;
  logic                  out_valid_r;
  logic [PAY_W-1:0]      out_data_r;
  logic                  out_last_r;

  logic            accept;
  logic            div_start, div_busy, div_done;
  logic [DW-1:0]   div_num, div_den;
  logic [RW-1:0]   div_quo;
  logic            load_out;
  logic            mul_pr_sel;
  logic [RW:0]     mul_a;
  logic [RW-1:0]   mul_b;
  logic [RW-1:0]   x0, x1;
  logic [PW-1:0]   acc_sum;
  logic [AW-1:0]   acc_sat;
  logic [AW-1:0]   acc_base;

  assign accept = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (accept) state_nxt = ST_DIV_TPR;
      ST_DIV_TPR:  if (div_done) state_nxt = ST_DIV_FPR;
      ST_DIV_FPR:  if (div_done) state_nxt = ST_DIV_PREC;
      ST_DIV_PREC: if (div_done) state_nxt = ST_MUL_ROC;
      ST_MUL_ROC:  state_nxt = ST_MUL_PR;
      ST_MUL_PR:   state_nxt = ST_ACC_PR;
      ST_ACC_PR:   state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    div_start  = 1'b0;
    mul_pr_sel = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_DIV_TPR, ST_DIV_FPR, ST_DIV_PREC: div_start = !div_busy && !div_done;
      ST_MUL_ROC:  mul_pr_sel = 1'b0;
      ST_MUL_PR:   mul_pr_sel = 1'b1;
      ST_ACC_PR:   mul_pr_sel = 1'b1;
      ST_DONE:     load_out = !out_valid_r || out_tready;
      default:     in_tready = 1'b0;
    endcase
  end

  // divider operands; a zero total acts as one
  always_comb begin
    div_num = DW'(pos_r);
    div_den = DW'(COUNT_BITS'(1));
    case (state_r)
      ST_DIV_TPR: div_den = (tot_pos_r == '0) ? DW'(1) : DW'(tot_pos_r);
      ST_DIV_FPR: begin
        div_num = DW'(neg_r);
        div_den = (tot_neg_r == '0) ? DW'(1) : DW'(tot_neg_r);
      end
      ST_DIV_PREC: div_den = DW'({1'b0, pos_r} + {1'b0, neg_r});
      default: div_den = DW'(1);
    endcase
  end

  rpaa_div #(
    .DW        (DW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier: (y0 + y1) * dx, a falling x gives zero width
  always_comb begin
    x0    = mul_pr_sel ? prev_tpr_r : prev_fpr_r;
    x1    = mul_pr_sel ? tpr_r : fpr_r;
    mul_b = (x1 > x0) ? RW'(x1 - x0) : '0;
    mul_a = mul_pr_sel ? ({1'b0, prev_prec_r} + {1'b0, prec_r})
                       : ({1'b0, prev_tpr_r} + {1'b0, tpr_r});
  end

  // accumulate the registered product into ROC in ST_MUL_PR, into PR in ST_ACC_PR
  always_comb begin
    acc_base = (state_r == ST_ACC_PR) ? pr_sum_r : roc_sum_r;
    acc_sum  = PW'(acc_base) + (prod_r >> 1);
    acc_sat  = (acc_sum > PW'(ONE_AREA)) ? ONE_AREA : AW'(acc_sum);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_pos_r <= REG_BITS'(1);
      tot_neg_r <= REG_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOTAL_POS: tot_pos_r <= cfg_wdata;
        REG_TOTAL_NEG: tot_neg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      neg_r       <= '0;
      last_r      <= 1'b0;
      prev_tpr_r  <= '0;
      prev_fpr_r  <= '0;
      prev_prec_r <= ONE_Q;
      roc_sum_r   <= '0;
      pr_sum_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (accept) begin
        last_r <= in_tlast;
        // hold the counts at full scale
        if (in_tdata[0]) begin
          if (pos_r != '1) pos_r <= pos_r + 1'b1;
        end else begin
          if (neg_r != '1) neg_r <= neg_r + 1'b1;
        end
      end

      if (div_done) begin
        case (state_r)
          ST_DIV_TPR:  tpr_r  <= div_quo;
          ST_DIV_FPR:  fpr_r  <= div_quo;
          ST_DIV_PREC: prec_r <= div_quo;
          default: ;
        endcase
      end

      if (state_r == ST_MUL_ROC || state_r == ST_MUL_PR) prod_r <= PW'(mul_a * mul_b);
      if (state_r == ST_MUL_PR) roc_sum_r <= acc_sat;
      if (state_r == ST_ACC_PR) pr_sum_r <= acc_sat;

      if (load_out) begin
        out_data_r  <= {pr_sum_r, roc_sum_r, prec_r, tpr_r, fpr_r};
        out_last_r  <= last_r;
        if (last_r) begin
          // end of list: drop all list state
          pos_r       <= '0;
          neg_r       <= '0;
          prev_tpr_r  <= '0;
          prev_fpr_r  <= '0;
          prev_prec_r <= ONE_Q;
          roc_sum_r   <= '0;
          pr_sum_r    <= '0;
        end else begin
          prev_tpr_r  <= tpr_r;
          prev_fpr_r  <= fpr_r;
          prev_prec_r <= prec_r;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: design/rpaa_div.sv
`default_nettype none
// Restoring divider for fractions: quo = (num << FRAC_BITS) / den, saturated at 1.0.
// One quotient bit a cycle; a numerator not below the divisor saturates at once.
module rpaa_div #(
  parameter int DW        = 21,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DW-1:0]        num,
  input  wire logic [DW-1:0]        den,
  output logic                      busy,
  output logic                      done,
  output logic [FRAC_BITS:0]        quo
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic                 busy_r;
  logic                 done_r;
  logic                 sat_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        den_r;
  logic [FRAC_BITS-1:0] q_r;

  logic [DW:0]   shifted;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? DW'(shifted - {1'b0, den_r}) : DW'(shifted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (sat_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[FRAC_BITS-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end else if (start) begin
        busy_r <= 1'b1;
        sat_r  <= num >= den;
        cnt_r  <= '0;
        rem_r  <= num;
        den_r  <= den;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = sat_r ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q_r};

endmodule
`default_nettype wire

FILE: sim/rpaa_checker.sv
`timescale 1ns / 100ps
module rpaa_checker
  import rpaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // [0] is_positive, zero padded
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // from bit 0: false_pos_rate, true_pos_rate, precision, roc_auc, pr_area, zero padded
  input  logic [119:0]         out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_BITS-1:0]  cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  localparam int          FRAC      = 16;
  localparam logic [19:0] COUNT_MAX = 20'hfffff;
  localparam logic [63:0] ONE_RATE  = 64'd1 << FRAC;
  localparam logic [63:0] ONE_AREA  = 64'd1 << (2 * FRAC);

  typedef struct packed {
    logic [16:0] fpr;
    logic [16:0] tpr;
    logic [16:0] prec;
    logic [32:0] roc;
    logic [32:0] pr;
    logic        fin;
  } curve_point_t;

  logic [19:0] total_pos, total_neg;
  logic [19:0] pos_seen, neg_seen;
  logic [16:0] prev_tpr, prev_fpr, prev_prec;
  logic [32:0] roc_sum, pr_sum;
  curve_point_t expected_points[$];

  function automatic void clear_list();
    pos_seen  = '0;
    neg_seen  = '0;
    prev_tpr  = '0;
    prev_fpr  = '0;
    prev_prec = 17'(ONE_RATE);
    roc_sum   = '0;
    pr_sum    = '0;
  endfunction

  function automatic logic [16:0] rate_q(logic [19:0] count, logic [19:0] total);
    logic [63:0] d;
    logic [63:0] q;
    d = (total == '0) ? 64'd1 : 64'(total);
    q = (64'(count) << FRAC) / d;
    return (q > ONE_RATE) ? 17'(ONE_RATE) : q[16:0];
  endfunction

  // drop the width of a step whose x coordinate falls
  function automatic logic [32:0] trap_add(logic [32:0] sum, logic [16:0] x0,
                                           logic [16:0] y0, logic [16:0] x1,
                                           logic [16:0] y1);
    logic [63:0] dx;
    logic [63:0] s;
    dx = (x1 > x0) ? 64'(x1 - x0) : 64'd0;
    s  = 64'(sum) + (((64'(y0) + 64'(y1)) * dx) >> 1);
    return (s > ONE_AREA) ? 33'(ONE_AREA) : s[32:0];
  endfunction

  function automatic curve_point_t next_point(logic positive, logic lst);
    curve_point_t p;
    if (positive) begin
      if (pos_seen != COUNT_MAX) pos_seen = pos_seen + 1'b1;
    end else begin
      if (neg_seen != COUNT_MAX) neg_seen = neg_seen + 1'b1;
    end
    p.tpr  = rate_q(pos_seen, total_pos);
    p.fpr  = rate_q(neg_seen, total_neg);
    p.prec = 17'((64'(pos_seen) << FRAC) / (64'(pos_seen) + 64'(neg_seen)));
    roc_sum = trap_add(roc_sum, prev_fpr, prev_tpr, p.fpr, p.tpr);
    pr_sum  = trap_add(pr_sum, prev_tpr, prev_prec, p.tpr, p.prec);
    prev_tpr  = p.tpr;
    prev_fpr  = p.fpr;
    prev_prec = p.prec;
    p.roc = roc_sum;
    p.pr  = pr_sum;
    p.fin = lst;
    if (lst) clear_list();
    return p;
  endfunction

  always @(posedge clk) begin
    curve_point_t got;
    curve_point_t want;
    if (!rst_n) begin
      total_pos = 20'd1;
      total_neg = 20'd1;
      clear_list();
      expected_points.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.fpr  = out_tdata[16:0];
        got.tpr  = out_tdata[33:17];
        got.prec = out_tdata[50:34];
        got.roc  = out_tdata[83:51];
        got.pr   = out_tdata[116:84];
        got.fin  = out_tlast;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: fpr %0d tpr %0d prec %0d roc %0d pr %0d last %0b",
                     got.fpr, got.tpr, got.prec, got.roc, got.pr, got.fin);
        end else begin
          want = expected_points.pop_front();
          if (got.fpr != want.fpr || got.tpr != want.tpr || got.prec != want.prec ||
              got.roc != want.roc || got.pr != want.pr || got.fin != want.fin) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch (expected/actual): fpr %0d/%0d tpr %0d/%0d prec %0d/%0d",
                       want.fpr, got.fpr, want.tpr, got.tpr, want.prec, got.prec);
              $display("  roc %0d/%0d pr %0d/%0d last %0b/%0b",
                       want.roc, got.roc, want.pr, got.pr, want.fin, got.fin);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_points.insert(expected_points.size(), next_point(in_tdata[0], in_tlast));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TOTAL_POS: total_pos = cfg_wdata;
          REG_TOTAL_NEG: total_neg = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending <= expected_points.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import rpaa_pkg::*;

  localparam int          LIST_ITEMS  = 1550;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_WAIT  = 100;
  localparam logic [19:0] TOTAL_MAX   = 20'hfffff;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [119:0]         out_tdata;
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_TOTAL_POS;
  logic [REG_BITS-1:0]  cfg_wdata  = '0;

  int mismatches;
  int pending;

  int          cycle_count = 0;
  int          burst_left  = 0;
  logic        no_idle     = 1'b0;
  logic        hold_start  = 1'b0;
  int          hold_cnt    = 0;
  logic [31:0] rx_cycle    = '0;
  int          rx_mode     = 0;

  roc_pr_area_accumulator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rpaa_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_start) begin
        hold_cnt   <= 800;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 7) == 0);
          default: out_tready <= (rx_cycle[3:0] < 4'd11);
        endcase
      end
    end
  end

  task automatic send_label(input logic positive, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 8);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, positive};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold until every request has its result
  task automatic drain();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_totals(input logic [19:0] positives, input logic [19:0] negatives);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TOTAL_POS;
    cfg_wdata <= positives;
    @(posedge clk);
    cfg_index <= REG_TOTAL_NEG;
    cfg_wdata <= negatives;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [19:0] pick_total();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return 20'd1;
    if (sel < 4) return TOTAL_MAX;
    if (sel == 4) return 20'd0;
    if (sel < 15) return 20'($urandom_range(1, 64));
    return 20'($urandom_range(1, 1048575));
  endfunction

  initial begin
    int labels_sent;
    int list_left;
    int pos_bias;
    int phase_len;
    int phase_no;
    labels_sent = 0;
    list_left   = 0;
    pos_bias    = 50;
    phase_no    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // totals at their reset value
    send_label(1'b1, 1'b0);
    send_label(1'b0, 1'b0);
    send_label(1'b1, 1'b1);
    drain();

    // zero totals act as one
    set_totals(20'd0, 20'd0);
    send_label(1'b1, 1'b0);
    send_label(1'b0, 1'b0);
    send_label(1'b0, 1'b1);
    drain();

    set_totals(TOTAL_MAX, TOTAL_MAX);
    send_label(1'b0, 1'b0);
    send_label(1'b1, 1'b0);
    send_label(1'b1, 1'b0);
    send_label(1'b0, 1'b1);
    drain();

    // one-item lists, all-positive and all-negative
    set_totals(20'd1, 20'd1);
    send_label(1'b1, 1'b1);
    send_label(1'b0, 1'b1);
    // ROC area reaches 1.0, then falling FPR and saturation of the area
    send_label(1'b1, 1'b0);
    send_label(1'b0, 1'b0);
    drain();
    set_totals(20'd1, 20'd4);
    send_label(1'b0, 1'b0);
    drain();
    set_totals(20'd1, 20'd2);
    send_label(1'b0, 1'b0);
    drain();
    // falling recall on the PR curve
    set_totals(20'd3, 20'd2);
    send_label(1'b1, 1'b0);
    send_label(1'b1, 1'b1);
    drain();

    while (labels_sent < LIST_ITEMS) begin
      set_totals(pick_total(), pick_total());
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 80);
      if (phase_no == 0) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      // phases need not end on a list boundary, so totals change mid-list too
      repeat (phase_len) begin
        if (list_left == 0) begin
          list_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 60);
          pos_bias  = $urandom_range(0, 100);
        end
        send_label($urandom_range(0, 99) < pos_bias, list_left == 1);
        list_left--;
        labels_sent++;
      end
      drain();
      phase_no++;
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
